// ----- rtl/core/ufej_pkg.sv -----
// ----------------------------------------------------------------------------
// ufej_pkg
// Shared types and constants of the union-find edge joiner.
// ----------------------------------------------------------------------------
package ufej_pkg;

  localparam int unsigned CellW       = 10;
  localparam int unsigned WallW       = 11;
  localparam int unsigned CfgW        = 11;
  localparam int unsigned RankW       = 4;
  localparam int unsigned InDataW     = 32;
  localparam int unsigned OutDataW    = 16;
  localparam int unsigned MaxCellsDef = 1024;
  localparam int unsigned CellsRst    = 1024;

  localparam logic [RankW-1:0] RankMax = '1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_FCHK,
    ST_CWR,
    ST_LINK,
    ST_BUMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             cmd;
    logic             bad;
    logic [CellW-1:0] cell_a;
    logic [CellW-1:0] cell_b;
  } req_t;

  typedef struct packed {
    logic valid;
    logic removed;
    logic bad;
  } resp_t;

endpackage

// ----- rtl/core/ufej_ram.sv -----
// ----------------------------------------------------------------------------
// ufej_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ufej_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ufej_ctrl.sv -----
// ----------------------------------------------------------------------------
// ufej_ctrl
// Sequencer for root search, path compression, link by rank and store sweep.
// ----------------------------------------------------------------------------
module ufej_ctrl #(
  parameter int unsigned MaxCells = ufej_pkg::MaxCellsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ufej_pkg::req_t req_i,
  output logic           ready_o,
  output ufej_pkg::resp_t resp_o,
  input  logic           ack_i
);
  import ufej_pkg::*;

  localparam int unsigned AW = $clog2(MaxCells);
  localparam int unsigned WW = RankW + AW;

  // store word: {rank, parent}
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;
  logic [AW-1:0] rd_par;
  logic [RankW-1:0] rd_rank;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          cmd_q, cmd_d;
  logic          phase_q, phase_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] orig_q, orig_d;
  logic [AW-1:0] root_q, root_d;
  logic [AW-1:0] ra_q, ra_d;
  logic [AW-1:0] rb_q, rb_d;
  logic [AW-1:0] cell_b_q, cell_b_d;
  logic [RankW-1:0] rank_a_q, rank_a_d;
  logic [RankW-1:0] rank_b_q, rank_b_d;
  logic          removed_q, removed_d;
  logic          bad_q, bad_d;
  logic          phase_end;

  assign rd_par  = ram_rdata[AW-1:0];
  assign rd_rank = ram_rdata[WW-1:AW];

  ufej_ram #(
    .Width (WW),
    .Depth (MaxCells)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cmd_d     = cmd_q;
    phase_d   = phase_q;
    cur_d     = cur_q;
    orig_d    = orig_q;
    root_d    = root_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    cell_b_d  = cell_b_q;
    rank_a_d  = rank_a_q;
    rank_b_d  = rank_b_q;
    removed_d = removed_q;
    bad_d     = bad_q;
    phase_end = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = '0;
    ram_raddr = cur_q;
    ready_o   = 1'b0;
    resp_o    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = {RankW'(0), clr_q};
        if (clr_q == AW'(MaxCells - 1)) begin
          clr_d     = '0;
          cmd_d     = 1'b0;
          removed_d = 1'b0;
          bad_d     = 1'b0;
          state_d   = cmd_q ? ST_DONE : ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          removed_d = 1'b0;
          bad_d     = 1'b0;
          if (req_i.cmd) begin
            cmd_d   = 1'b1;
            clr_d   = '0;
            state_d = ST_CLEAR;
          end else if (req_i.bad) begin
            bad_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            phase_d  = 1'b0;
            cur_d    = AW'(req_i.cell_a);
            orig_d   = AW'(req_i.cell_a);
            cell_b_d = AW'(req_i.cell_b);
            state_d  = ST_FIND;
          end
        end
      end
      ST_FIND: begin
        ram_raddr = cur_q;
        state_d   = ST_FCHK;
      end
      ST_FCHK: begin
        if (rd_par == cur_q) begin
          root_d = cur_q;
          if (!phase_q) begin
            ra_d     = cur_q;
            rank_a_d = rd_rank;
          end else begin
            rb_d     = cur_q;
            rank_b_d = rd_rank;
          end
          if (orig_q == cur_q) begin
            phase_end = 1'b1;
          end else begin
            // second pass: repoint every node on the path at the root
            cur_d     = orig_q;
            ram_raddr = orig_q;
            state_d   = ST_CWR;
          end
        end else begin
          cur_d     = rd_par;
          ram_raddr = rd_par;
        end
      end
      ST_CWR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = {rd_rank, root_q};
        if (rd_par == root_q) begin
          phase_end = 1'b1;
        end else begin
          cur_d     = rd_par;
          ram_raddr = rd_par;
        end
      end
      ST_LINK: begin
        if (ra_q == rb_q) begin
          state_d = ST_DONE;
        end else if (rank_a_q > rank_b_q) begin
          ram_we    = 1'b1;
          ram_waddr = rb_q;
          ram_wdata = {rank_b_q, ra_q};
          removed_d = 1'b1;
          state_d   = ST_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ra_q;
          ram_wdata = {rank_a_q, rb_q};
          removed_d = 1'b1;
          state_d   = (rank_a_q == rank_b_q && rank_b_q != RankMax) ? ST_BUMP : ST_DONE;
        end
      end
      ST_BUMP: begin
        ram_we    = 1'b1;
        ram_waddr = rb_q;
        ram_wdata = {rank_b_q + RankW'(1), rb_q};
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        resp_o.valid   = 1'b1;
        resp_o.removed = removed_q;
        resp_o.bad     = bad_q;
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (phase_end) begin
      if (!phase_q) begin
        phase_d = 1'b1;
        cur_d   = cell_b_q;
        orig_d  = cell_b_q;
        state_d = ST_FIND;
      end else begin
        state_d = ST_LINK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cmd_q   <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    orig_q    <= orig_d;
    root_q    <= root_d;
    ra_q      <= ra_d;
    rb_q      <= rb_d;
    cell_b_q  <= cell_b_d;
    rank_a_q  <= rank_a_d;
    rank_b_q  <= rank_b_d;
    removed_q <= removed_d;
    bad_q     <= bad_d;
  end

endmodule

// ----- rtl/core/union_find_edge_joiner.sv -----
// ----------------------------------------------------------------------------
// union_find_edge_joiner
// Disjoint-set engine over maze cells: joins the sets of a wall's two cells.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A wall edge walks from both cells to their roots,
// with one more step when equal ranks raise the new root's rank: each hop costs
// one read on the way up and one repointing write on the way back, and path
// compression keeps the chains short. Every step works on the single parent/rank
// store, whose registered read sets the pace. A bad cell index goes straight to
// the result. After reset, and for every reset command, the store is swept one
// entry per cycle, during which no beat is taken (config writes still are).
// A finished result sits in the output register while the next beat comes in.
module union_find_edge_joiner #(
  parameter int unsigned MaxCells = ufej_pkg::MaxCellsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config: cells_in_use
  input  logic                           cfg_we_i,
  input  logic [ufej_pkg::CfgW-1:0]      cfg_wdata_i,
  // input beat
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [10:0] wall_index, [20:11] cell_a, [30:21] cell_b, [31] zero
  input  logic [ufej_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [0] command
  input  logic                           s_axis_tuser_i,
  // result beat
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [10:0] wall_echo, [11] wall_removed, [12] bad_cell, [15:13] zero
  output logic [ufej_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import ufej_pkg::*;

  localparam int unsigned AW   = $clog2(MaxCells);
  localparam int unsigned CmpW = (CfgW > AW + 1) ? CfgW : AW + 1;

  logic [CfgW-1:0]     cells_q;
  logic [CmpW-1:0]     limit;
  logic [CellW-1:0]    in_cell_a;
  logic [CellW-1:0]    in_cell_b;
  logic [WallW-1:0]    in_wall;
  logic                accept;
  req_t                req;
  resp_t               resp;
  logic                ack;
  logic [WallW-1:0]    wall_q;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;

  assign in_wall   = s_axis_tdata_i[WallW-1:0];
  assign in_cell_a = s_axis_tdata_i[WallW+CellW-1:WallW];
  assign in_cell_b = s_axis_tdata_i[WallW+2*CellW-1:WallW+CellW];

  // cells_in_use above the store size acts as the store size
  assign limit = (CmpW'(cells_q) > CmpW'(MaxCells)) ? CmpW'(MaxCells) : CmpW'(cells_q);

  assign req.cmd    = s_axis_tuser_i;
  assign req.bad    = (CmpW'(in_cell_a) >= limit) || (CmpW'(in_cell_b) >= limit);
  assign req.cell_a = in_cell_a;
  assign req.cell_b = in_cell_b;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  ufej_ctrl #(
    .MaxCells (MaxCells)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .req_i   (req),
    .ready_o (s_axis_tready_o),
    .resp_o  (resp),
    .ack_i   (ack)
  );

  assign ack = resp.valid && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (ack) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q     <= CfgW'(CellsRst);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cells_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wall_q <= s_axis_tuser_i ? '0 : in_wall;
    end
    if (ack) begin
      out_data_q <= OutDataW'({resp.bad, resp.removed, wall_q});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // the block is busy in the cycle after every accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("input taken on two consecutive cycles");

  // a finished result waits in the sequencer while the output slot is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp.valid && out_valid_q && !m_axis_tready_i |=> resp.valid && $stable(resp))
    else $error("pending result lost while output stalled");

  // a bad cell never joins sets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp.valid |-> !(resp.bad && resp.removed))
    else $error("bad cell result reports a removed wall");

  // the sequencer is never ready while it still holds a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp.valid |-> !s_axis_tready_o)
    else $error("ready while a result is pending");

endmodule

// ----- tb/sv/union_find_edge_joiner_tb.sv -----
// ----------------------------------------------------------------------------
// union_find_edge_joiner_tb
// Self-checking bench for the union-find edge joiner. A local disjoint-set
// model (path compression, link by rank) predicts every result beat; beats are
// checked field by field in order. Directed edges and range cases come first,
// then random forests over several cell counts and full shuffled maze grids,
// with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module union_find_edge_joiner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCells   = ufej_pkg::MaxCellsDef;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PrintCap   = 40;

  localparam logic CmdEdge  = 1'b0;
  localparam logic CmdClear = 1'b1;

  typedef logic [ufej_pkg::CellW-1:0] cell_t;
  typedef logic [ufej_pkg::WallW-1:0] wall_t;
  typedef logic [ufej_pkg::RankW-1:0] rank_t;

  typedef struct packed {
    wall_t wall;
    logic  removed;
    logic  bad;
  } joiner_result_t;

  typedef struct packed {
    wall_t rank;
    cell_t a;
    cell_t b;
  } maze_wall_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [ufej_pkg::CfgW-1:0]      cfg_wdata;
  logic                           s_tvalid;
  logic                           s_axis_tready_o;
  logic [ufej_pkg::InDataW-1:0]   s_tdata;
  logic                           s_tuser;
  logic                           m_axis_tvalid_o;
  logic                           m_tready;
  logic [ufej_pkg::OutDataW-1:0]  m_axis_tdata_o;

  union_find_edge_joiner #(
    .MaxCells(MaxCells)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // model of the cell forest
  cell_t                       parent_tbl [MaxCells];
  logic [ufej_pkg::RankW-1:0]  rank_tbl   [MaxCells];
  int unsigned                 cells_cfg;

  joiner_result_t expected_results [$];

  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned beats_checked;
  int unsigned walls_removed;
  int unsigned bad_flags;
  int unsigned clears_sent;
  int unsigned cycle_count;
  int unsigned gap_to_next;
  bit          burst_mode;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic void clear_forest();
    for (int i = 0; i < MaxCells; i++) begin
      parent_tbl[i] = cell_t'(i);
      rank_tbl[i]   = '0;
    end
  endfunction

  // find with full path compression
  function automatic cell_t find_root(cell_t leaf);
    cell_t       root;
    cell_t       cur;
    cell_t       nxt;
    int unsigned steps;
    root  = leaf;
    steps = 0;
    while (parent_tbl[root] != root && steps < MaxCells) begin
      root = parent_tbl[root];
      steps++;
    end
    cur   = leaf;
    steps = 0;
    while (cur != root && steps < MaxCells) begin
      nxt             = parent_tbl[cur];
      parent_tbl[cur] = root;
      cur             = nxt;
      steps++;
    end
    return root;
  endfunction

  function automatic joiner_result_t predict_join(logic cmd, wall_t wall, cell_t a, cell_t b);
    joiner_result_t r;
    cell_t          ra;
    cell_t          rb;
    int unsigned    lim;
    r   = '0;
    lim = (cells_cfg > MaxCells) ? MaxCells : cells_cfg;
    if (cmd == CmdClear) begin
      clear_forest();
      return r;
    end
    r.wall = wall;
    if (32'(a) >= lim || 32'(b) >= lim) begin
      r.bad = 1'b1;
      return r;
    end
    ra = find_root(a);
    rb = find_root(b);
    if (ra != rb) begin
      if (rank_tbl[ra] > rank_tbl[rb]) begin
        parent_tbl[rb] = ra;
      end else begin
        parent_tbl[ra] = rb;
        if (rank_tbl[ra] == rank_tbl[rb] && rank_tbl[rb] != ufej_pkg::RankMax)
          rank_tbl[rb] = rank_tbl[rb] + rank_t'(1);
      end
      r.removed = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= PrintCap)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // one input beat; the model is stepped at the accepting edge
  task automatic send_item(input logic cmd, input wall_t wall, input cell_t a, input cell_t b);
    joiner_result_t exp_res;
    repeat (gap_to_next) @(posedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, b, a, wall};
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    exp_res = predict_join(cmd, wall, a, b);
    expected_results.push_back(exp_res);
    items_sent++;
    if (cmd == CmdClear) clears_sent++;
    gap_to_next = draw_gap();
    if (gap_to_next != 0) s_tvalid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    if (gap_to_next == 0) begin
      s_tvalid    <= 1'b0;
      gap_to_next = 1;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cells_in_use(input logic [ufej_pkg::CfgW-1:0] value);
    wait_results_drained();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cells_cfg = 32'(value);
  endtask

  // result sink with random stalls
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_tready <= 1'b1;
      end else if (m_tready !== 1'b1) begin
        m_tready <= 1'b1;
      end
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin : result_check
    joiner_result_t exp_res;
    joiner_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.wall    = m_axis_tdata_o[ufej_pkg::WallW-1:0];
      got.removed = m_axis_tdata_o[ufej_pkg::WallW];
      got.bad     = m_axis_tdata_o[ufej_pkg::WallW+1];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat, wall_echo", 32'(got.wall), 0);
      end else begin
        exp_res = expected_results.pop_front();
        beats_checked++;
        if (exp_res.removed) walls_removed++;
        if (exp_res.bad) bad_flags++;
        if (got.wall != exp_res.wall)
          report_mismatch("wall_echo", 32'(got.wall), 32'(exp_res.wall));
        if (got.removed != exp_res.removed)
          report_mismatch("wall_removed", 32'(got.removed), 32'(exp_res.removed));
        if (got.bad != exp_res.bad)
          report_mismatch("bad_cell", 32'(got.bad), 32'(exp_res.bad));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // hand-built joins: equal ranks, higher rank wins, same cell, clear
  task automatic test_directed_joins();
    send_item(CmdEdge, 11'd0, 10'd0, 10'd0);
    send_item(CmdEdge, 11'd2047, 10'd0, 10'd1);
    send_item(CmdEdge, 11'd5, 10'd2, 10'd3);
    send_item(CmdEdge, 11'd6, 10'd0, 10'd3);
    send_item(CmdEdge, 11'd7, 10'd0, 10'd5);
    send_item(CmdEdge, 11'd8, 10'd1023, 10'd1022);
    send_item(CmdEdge, 11'd9, 10'd2, 10'd1);
    send_item(CmdEdge, 11'h555, 10'd5, 10'd1023);
    send_item(CmdClear, 11'd2047, 10'd1023, 10'd1023);
    send_item(CmdEdge, 11'h2aa, 10'd0, 10'd1);
  endtask

  // range flagging at the register extremes, out-of-range values included
  task automatic test_cell_range();
    write_cells_in_use(11'd2);
    send_item(CmdEdge, 11'd10, 10'd1, 10'd0);
    send_item(CmdEdge, 11'd11, 10'd2, 10'd0);
    send_item(CmdEdge, 11'd12, 10'd0, 10'd2);
    send_item(CmdEdge, 11'd13, 10'd1023, 10'd1);
    write_cells_in_use(11'd0);
    send_item(CmdEdge, 11'd14, 10'd0, 10'd0);
    write_cells_in_use(11'd1);
    send_item(CmdEdge, 11'd15, 10'd0, 10'd0);
    send_item(CmdEdge, 11'd16, 10'd0, 10'd1);
    write_cells_in_use(11'd2047);
    send_item(CmdEdge, 11'd17, 10'd1023, 10'd0);
    write_cells_in_use(11'd1024);
  endtask

  // random edges over n_cells, with clears, bad cells (when n_cells < MaxCells) and one full drain
  task automatic test_random_forest(input int unsigned n_cells, input int unsigned n_items);
    int unsigned pick;
    cell_t       a;
    cell_t       b;
    write_cells_in_use(n_cells[ufej_pkg::CfgW-1:0]);
    for (int unsigned k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      a    = cell_t'($urandom_range(0, n_cells - 1));
      b    = cell_t'($urandom_range(0, n_cells - 1));
      if (pick < 3) begin
        send_item(CmdClear, wall_t'($urandom), cell_t'($urandom), cell_t'($urandom));
      end else if (pick < 9 && n_cells < MaxCells) begin
        if (pick[0]) a = cell_t'($urandom_range(n_cells, MaxCells - 1));
        else         b = cell_t'($urandom_range(n_cells, MaxCells - 1));
        send_item(CmdEdge, wall_t'($urandom), a, b);
      end else begin
        send_item(CmdEdge, wall_t'($urandom), a, b);
      end
      if (k == n_items / 2) wait_results_drained();
    end
  endtask

  // every wall of a w x h grid once, shuffled, with a little noise
  task automatic test_maze_grid(input int unsigned w, input int unsigned h, input bit burst);
    maze_wall_t  walls [$];
    maze_wall_t  tmp;
    maze_wall_t  mw;
    int unsigned j;
    int unsigned c;
    write_cells_in_use(11'(w * h));
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        c = y * w + x;
        if (x + 1 < w) walls.push_back('{wall_t'(walls.size()), cell_t'(c), cell_t'(c + 1)});
        if (y + 1 < h) walls.push_back('{wall_t'(walls.size()), cell_t'(c), cell_t'(c + w)});
      end
    end
    for (int i = walls.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = walls[i];
      walls[i] = walls[j];
      walls[j] = tmp;
    end
    send_item(CmdClear, wall_t'($urandom), cell_t'($urandom), cell_t'($urandom));
    burst_mode = burst;
    foreach (walls[i]) begin
      if (i == walls.size() / 2) burst_mode = 1'b0;
      mw = walls[i];
      if ($urandom_range(0, 1)) send_item(CmdEdge, mw.rank, mw.a, mw.b);
      else                      send_item(CmdEdge, mw.rank, mw.b, mw.a);
      if ($urandom_range(0, 19) == 0)
        send_item(CmdEdge, wall_t'($urandom),
                  cell_t'($urandom_range(w * h, MaxCells - 1)), mw.a);
    end
    burst_mode = 1'b0;
  endtask

  initial begin : main
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= 1'b0;
    m_tready    <= 1'b0;
    cycle_count = 0;
    gap_to_next = 1;
    burst_mode  = 1'b0;
    cells_cfg   = ufej_pkg::CellsRst;
    clear_forest();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_joins();
    test_cell_range();
    test_random_forest(16, 130);
    test_maze_grid(2, 1, 1'b0);
    test_maze_grid(8, 8, 1'b0);
    test_maze_grid(16, 8, 1'b1);
    // no clear between these: the store must survive register writes
    test_random_forest(1024, 100);
    test_random_forest(40, 60);
    test_random_forest(1024, 40);

    wait_results_drained();
    repeat (64) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());
    $display("Covered %0d input beats (%0d clears), %0d results checked.",
             items_sent, clears_sent, beats_checked);
    $display("Walls removed: %0d, bad cell flags: %0d, mismatches: %0d.",
             walls_removed, bad_flags, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ufej_pkg.sv
rtl/core/ufej_ram.sv
rtl/core/ufej_ctrl.sv
rtl/core/union_find_edge_joiner.sv
tb/sv/union_find_edge_joiner_tb.sv
